@@ sv/gcl_pkg.sv @@
// Shared constants, types and helpers for the viewer grid cell locator.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none

package gcl_pkg;

	localparam int GRID_DEPTH = 8;
	localparam int MAX_SIDE   = 32;

	localparam int POS_W   = 32;
	localparam int EXT_W   = POS_W + 3;
	localparam int CNT_W   = 6;
	localparam int NUM_W   = POS_W + CNT_W;
	localparam int STEP_W  = $clog2(CNT_W);
	localparam int CELL_W  = 15;
	localparam int TBL_DEPTH = 1024;
	localparam int TBL_AW  = $clog2(TBL_DEPTH);
	localparam int IDX_W   = 3;

	localparam logic [CNT_W:0]   MAX_SIDE_V   = (CNT_W + 1)'(MAX_SIDE);
	localparam logic [CNT_W-1:0] GRID_DEPTH_V = CNT_W'(GRID_DEPTH);

	localparam logic MODE_LOCATE = 1'b0;
	localparam logic MODE_COLUMN = 1'b1;

	typedef enum logic [IDX_W-1:0] {
		REG_MIN_X, REG_MIN_Y, REG_MIN_Z, REG_MAX_X, REG_MAX_Y, REG_MAX_Z,
		REG_CELLS_X, REG_CELLS_Y
	} cfg_reg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [POS_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	function automatic logic signed [EXT_W-1:0] sext(input logic signed [POS_W-1:0] v);
		sext = {{(EXT_W - POS_W){v[POS_W-1]}}, v};
	endfunction

endpackage

`default_nettype wire

@@ sv/gcl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gcl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ sv/gcl_div.sv @@
// Restoring divider, one quotient bit per cycle, for the cell index of one axis.
// Depends on gcl_pkg for widths and the request and status structs.
`default_nettype none

module gcl_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire gcl_pkg::div_req_t        req,
	output gcl_pkg::div_sts_t             sts,
	output logic [gcl_pkg::CNT_W-1:0]     quo
);

	logic                         busy_q;
	logic                         done_q;
	logic [gcl_pkg::STEP_W-1:0]   step_q;
	logic [gcl_pkg::NUM_W-1:0]    rem_q;
	logic [gcl_pkg::NUM_W-1:0]    den_sh_q;
	logic [gcl_pkg::CNT_W-1:0]    quo_q;
	logic                         take;

	// quotient never exceeds the cell count, so CNT_W bits cover it
	assign take = (rem_q >= den_sh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= gcl_pkg::STEP_W'(gcl_pkg::CNT_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - gcl_pkg::STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q    <= req.num;
			den_sh_q <= gcl_pkg::NUM_W'(req.den) << (gcl_pkg::CNT_W - 1);
			quo_q    <= '0;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - den_sh_q;
			end
			den_sh_q <= den_sh_q >> 1;
			quo_q    <= {quo_q[gcl_pkg::CNT_W-2:0], take};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = quo_q;

endmodule

`default_nettype wire

@@ sv/viewer_grid_cell_locator.sv @@
// Viewer grid cell locator: finds the grid cell holding a viewer position.
// A located position is offset, scaled and divided per axis, X then Y, then the column
// offset read and Z follows; a miss ends early. Each axis runs the 6-step serial divider.
// Input stalls until each result is registered; column offset writes give no result.
// After reset the 1024-entry offset table is cleared entry by entry with input stalled.
// Depends on gcl_pkg, gcl_ram and gcl_div.
`default_nettype none

module viewer_grid_cell_locator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          mode,
	input  wire logic signed [31:0]            pos_x,
	input  wire logic signed [31:0]            pos_y,
	input  wire logic signed [31:0]            pos_z,
	input  wire logic [9:0]                    column_slot,
	input  wire logic signed [31:0]            column_offset,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               cell_found,
	output logic [14:0]                        cell_number,
	output logic                               cell_changed,
	output logic                               left_grid,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [gcl_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [31:0]                   cfg_data
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_SUB, S_MUL, S_DIV, S_RD, S_RDW, S_CELL, S_CELL2, S_FIN
	} state_t;

	typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

	localparam int PW = 2 * gcl_pkg::CNT_W;
	localparam int CW = 3 * gcl_pkg::CNT_W;

	// configuration
	logic signed [31:0]           box_min_x_q, box_min_y_q, box_min_z_q;
	logic signed [31:0]           box_max_x_q, box_max_y_q, box_max_z_q;
	logic [gcl_pkg::CNT_W-1:0]    cells_x_q, cells_y_q;
	logic [gcl_pkg::CNT_W-1:0]    cx_eff, cy_eff;

	// control
	state_t                       state_q;
	axis_t                        axis_q;
	logic [gcl_pkg::TBL_AW-1:0]   clr_q;
	logic                         found_q;
	logic [14:0]                  cur_cell_q;
	logic                         cur_valid_q;
	logic                         inside_q;
	logic                         out_valid_q;
	logic                         cell_found_q;
	logic [14:0]                  cell_number_q;
	logic                         cell_changed_q;
	logic                         left_grid_q;

	// datapath
	logic signed [31:0]                 pos_x_q, pos_y_q, pos_z_q;
	logic signed [gcl_pkg::EXT_W-1:0]   d_q, rng_q, lo_z_q;
	logic signed [gcl_pkg::EXT_W-1:0]   p_sel, lo_sel, rng_sel;
	logic [gcl_pkg::CNT_W-1:0]          x_q, y_q, z_q, cnt_sel;
	logic [PW-1:0]                      plane_q, row_q, ycx, col_sum;
	logic [CW-1:0]                      cell_sum;
	logic [14:0]                        cell_q;
	logic                               axis_ok;
	logic                               in_acc;
	logic                               chg;

	// table and divider
	logic                               ram_we;
	logic [gcl_pkg::TBL_AW-1:0]         ram_waddr;
	logic [31:0]                        ram_wdata;
	logic [31:0]                        ram_rdata;
	gcl_pkg::div_req_t                  div_req;
	gcl_pkg::div_sts_t                  div_sts;
	logic [gcl_pkg::CNT_W-1:0]          div_quo;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// clamp cell counts to the largest side
	assign cx_eff = ({1'b0, cells_x_q} > gcl_pkg::MAX_SIDE_V) ?
		gcl_pkg::MAX_SIDE_V[gcl_pkg::CNT_W-1:0] : cells_x_q;
	assign cy_eff = ({1'b0, cells_y_q} > gcl_pkg::MAX_SIDE_V) ?
		gcl_pkg::MAX_SIDE_V[gcl_pkg::CNT_W-1:0] : cells_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_x_q <= '0;
			box_min_y_q <= '0;
			box_min_z_q <= '0;
			box_max_x_q <= 32'sd4096;
			box_max_y_q <= 32'sd4096;
			box_max_z_q <= 32'sd4096;
			cells_x_q   <= gcl_pkg::CNT_W'(1);
			cells_y_q   <= gcl_pkg::CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (gcl_pkg::cfg_reg_t'(cfg_index))
				gcl_pkg::REG_MIN_X:   box_min_x_q <= $signed(cfg_data);
				gcl_pkg::REG_MIN_Y:   box_min_y_q <= $signed(cfg_data);
				gcl_pkg::REG_MIN_Z:   box_min_z_q <= $signed(cfg_data);
				gcl_pkg::REG_MAX_X:   box_max_x_q <= $signed(cfg_data);
				gcl_pkg::REG_MAX_Y:   box_max_y_q <= $signed(cfg_data);
				gcl_pkg::REG_MAX_Z:   box_max_z_q <= $signed(cfg_data);
				gcl_pkg::REG_CELLS_X: cells_x_q   <= cfg_data[gcl_pkg::CNT_W-1:0];
				gcl_pkg::REG_CELLS_Y: cells_y_q   <= cfg_data[gcl_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// axis operand selection
	always_comb begin
		case (axis_q)
			AX_X: begin
				p_sel   = gcl_pkg::sext(pos_x_q);
				lo_sel  = gcl_pkg::sext(box_min_x_q);
				rng_sel = gcl_pkg::sext(box_max_x_q) - gcl_pkg::sext(box_min_x_q);
				cnt_sel = cx_eff;
			end
			AX_Y: begin
				p_sel   = gcl_pkg::sext(pos_y_q);
				lo_sel  = gcl_pkg::sext(box_min_y_q);
				rng_sel = gcl_pkg::sext(box_max_y_q) - gcl_pkg::sext(box_min_y_q);
				cnt_sel = cy_eff;
			end
			default: begin
				p_sel   = gcl_pkg::sext(pos_z_q);
				lo_sel  = lo_z_q;
				rng_sel = gcl_pkg::sext(box_max_z_q) - gcl_pkg::sext(box_min_z_q);
				cnt_sel = gcl_pkg::GRID_DEPTH_V;
			end
		endcase
	end

	// position must lie in the closed span of a non-empty axis
	assign axis_ok = !rng_q[gcl_pkg::EXT_W-1] && (rng_q != '0) && (cnt_sel != '0) &&
		!d_q[gcl_pkg::EXT_W-1] && (d_q <= rng_q);

	assign div_req.start = (state_q == S_MUL) && axis_ok;
	assign div_req.num   = gcl_pkg::NUM_W'(d_q[gcl_pkg::POS_W-1:0]) *
		gcl_pkg::NUM_W'(cnt_sel);
	assign div_req.den   = rng_q[gcl_pkg::POS_W-1:0];

	assign ycx      = PW'(y_q) * PW'(cx_eff);
	assign col_sum  = ycx + PW'(x_q);
	assign cell_sum = CW'(z_q) * CW'(plane_q) + CW'(row_q);
	assign chg      = !cur_valid_q || (cur_cell_q != cell_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (state_q == S_CLR) begin
			ram_we = 1'b1;
		end else if (in_acc && (mode == gcl_pkg::MODE_COLUMN)) begin
			ram_we    = 1'b1;
			ram_waddr = column_slot;
			ram_wdata = column_offset;
		end
	end

	gcl_ram #(
		.WIDTH(32),
		.DEPTH(gcl_pkg::TBL_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (col_sum[gcl_pkg::TBL_AW-1:0]),
		.rdata (ram_rdata)
	);

	gcl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			axis_q         <= AX_X;
			clr_q          <= '0;
			found_q        <= 1'b0;
			cur_cell_q     <= '0;
			cur_valid_q    <= 1'b0;
			inside_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			cell_found_q   <= 1'b0;
			cell_number_q  <= '0;
			cell_changed_q <= 1'b0;
			left_grid_q    <= 1'b0;
		end else begin
			// the final state drives the output valid on its own
			if (out_valid_q && !out_stall && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + gcl_pkg::TBL_AW'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc && (mode == gcl_pkg::MODE_LOCATE)) begin
						axis_q  <= AX_X;
						found_q <= 1'b0;
						state_q <= S_SUB;
					end
				end
				S_SUB: state_q <= S_MUL;
				S_MUL: state_q <= axis_ok ? S_DIV : S_FIN;
				S_DIV: begin
					if (div_sts.done) begin
						// far edge gives an index equal to the count: no cell
						if (div_quo >= cnt_sel) begin
							state_q <= S_FIN;
						end else begin
							case (axis_q)
								AX_X: begin
									axis_q  <= AX_Y;
									state_q <= S_SUB;
								end
								AX_Y: state_q <= S_RD;
								default: state_q <= S_CELL;
							endcase
						end
					end
				end
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					axis_q  <= AX_Z;
					state_q <= S_SUB;
				end
				S_CELL: state_q <= S_CELL2;
				S_CELL2: begin
					found_q <= 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the previous request has left the output
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (found_q) begin
							cell_found_q   <= 1'b1;
							cell_number_q  <= cell_q;
							cell_changed_q <= chg;
							left_grid_q    <= 1'b0;
							inside_q       <= 1'b1;
							if (chg) begin
								cur_cell_q  <= cell_q;
								cur_valid_q <= 1'b1;
							end
						end else begin
							cell_found_q   <= 1'b0;
							cell_number_q  <= '0;
							cell_changed_q <= 1'b0;
							left_grid_q    <= inside_q;
							if (inside_q) begin
								cur_cell_q  <= '0;
								cur_valid_q <= 1'b0;
								inside_q    <= 1'b0;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (mode == gcl_pkg::MODE_LOCATE)) begin
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
			pos_z_q <= pos_z;
		end
		case (state_q)
			S_SUB: begin
				d_q   <= p_sel - lo_sel;
				rng_q <= rng_sel;
			end
			S_DIV: begin
				if (div_sts.done) begin
					case (axis_q)
						AX_X: x_q <= div_quo;
						AX_Y: y_q <= div_quo;
						default: z_q <= div_quo;
					endcase
				end
			end
			S_RDW: lo_z_q <= gcl_pkg::sext(box_min_z_q) + gcl_pkg::sext($signed(ram_rdata));
			S_CELL: begin
				plane_q <= PW'(cx_eff) * PW'(cy_eff);
				row_q   <= col_sum;
			end
			S_CELL2: cell_q <= cell_sum[gcl_pkg::CELL_W-1:0];
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign cell_found   = cell_found_q;
	assign cell_number  = cell_number_q;
	assign cell_changed = cell_changed_q;
	assign left_grid    = left_grid_q;

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !cell_found_q |-> !cell_changed_q && (cell_number_q == '0))
		else $error("miss result carries a cell");

	a_left_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && left_grid_q |-> !cell_found_q)
		else $error("left grid flagged on a found cell");

	a_cur_track: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && cell_found_q |-> cur_valid_q && inside_q &&
		(cur_cell_q == cell_number_q))
		else $error("active cell does not follow the pending result");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == S_DIV) && !div_sts.busy)
		else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

@@ bench/tb_viewer_grid_cell_locator.sv @@
// Self-checking bench for viewer_grid_cell_locator: random and directed viewer positions,
// column offset writes and grid settings, checked against a cycle-free cell tracker.
// Depends on gcl_pkg and the viewer_grid_cell_locator RTL.
`default_nettype none

module tb_viewer_grid_cell_locator;

	localparam longint POS_MIN = -64'sd2147483648;
	localparam longint POS_MAX = 64'sd2147483647;
	localparam int QUIET_LIMIT = 8000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic        found;
		logic [14:0] number;
		logic        changed;
		logic        left;
	} cell_report_t;

	class viewer_cell_tracker;
		logic signed [31:0] lo_bound [3];
		logic signed [31:0] hi_bound [3];
		logic [5:0]         cnt_x, cnt_y;
		logic [31:0]        column_dz [1024];
		logic [14:0]        active_cell;
		bit                 active_valid;
		bit                 in_grid;
		cell_report_t       reports_due [$];
		int                 mismatches;

		function new();
			foreach (lo_bound[i]) begin
				lo_bound[i] = 32'sd0;
				hi_bound[i] = 32'sd4096;
			end
			cnt_x = 6'd1;
			cnt_y = 6'd1;
			foreach (column_dz[i]) column_dz[i] = '0;
			active_cell = '0;
			active_valid = 1'b0;
			in_grid = 1'b0;
			mismatches = 0;
		endfunction

		function int pending();
			return reports_due.size();
		endfunction

		function void write_register(gcl_pkg::cfg_reg_t idx, logic [31:0] v);
			case (idx)
				gcl_pkg::REG_MIN_X:   lo_bound[0] = v;
				gcl_pkg::REG_MIN_Y:   lo_bound[1] = v;
				gcl_pkg::REG_MIN_Z:   lo_bound[2] = v;
				gcl_pkg::REG_MAX_X:   hi_bound[0] = v;
				gcl_pkg::REG_MAX_Y:   hi_bound[1] = v;
				gcl_pkg::REG_MAX_Z:   hi_bound[2] = v;
				gcl_pkg::REG_CELLS_X: cnt_x = v[5:0];
				gcl_pkg::REG_CELLS_Y: cnt_y = v[5:0];
				default: ;
			endcase
		endfunction

		// Closed bounds test, then floor division; the far edge lands on index == count.
		function bit axis_hit(longint p, longint lo, longint hi, longint span, int unsigned count,
				output int unsigned idx);
			longint q;
			idx = 0;
			if (span <= 0 || count == 0) return 1'b0;
			if (p < lo || p > hi) return 1'b0;
			q = ((p - lo) * longint'(count)) / span;
			if (q >= longint'(count)) return 1'b0;
			idx = int'(q);
			return 1'b1;
		endfunction

		function void take_request(logic m, logic signed [31:0] px, logic signed [31:0] py,
				logic signed [31:0] pz, logic [9:0] slot, logic signed [31:0] off);
			int unsigned  cx, cy, ix, iy, iz;
			longint       dz, lo_z, hi_z;
			cell_report_t r;
			if (m == gcl_pkg::MODE_COLUMN) begin
				column_dz[slot] = off;
				return;
			end
			cx = (cnt_x > gcl_pkg::MAX_SIDE) ? gcl_pkg::MAX_SIDE : cnt_x;
			cy = (cnt_y > gcl_pkg::MAX_SIDE) ? gcl_pkg::MAX_SIDE : cnt_y;
			r = '0;
			if (axis_hit(px, lo_bound[0], hi_bound[0],
					longint'(hi_bound[0]) - longint'(lo_bound[0]), cx, ix) &&
				axis_hit(py, lo_bound[1], hi_bound[1],
					longint'(hi_bound[1]) - longint'(lo_bound[1]), cy, iy)) begin
				dz = longint'($signed(column_dz[(ix + iy * cx) % 1024]));
				lo_z = longint'(lo_bound[2]) + dz;
				hi_z = longint'(hi_bound[2]) + dz;
				if (axis_hit(pz, lo_z, hi_z, longint'(hi_bound[2]) - longint'(lo_bound[2]),
						gcl_pkg::GRID_DEPTH, iz)) begin
					r.found = 1'b1;
					r.number = 15'(iz * cx * cy + iy * cx + ix);
				end
			end
			if (r.found) begin
				if (!active_valid || active_cell != r.number) begin
					r.changed = 1'b1;
					active_cell = r.number;
					active_valid = 1'b1;
				end
				in_grid = 1'b1;
			end else if (in_grid) begin
				r.left = 1'b1;
				active_cell = '0;
				active_valid = 1'b0;
				in_grid = 1'b0;
			end
			reports_due = {reports_due, r};
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 50) $display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		task check_report(logic f, logic [14:0] n, logic c, logic l);
			cell_report_t want;
			if (reports_due.size() == 0) begin
				report_mismatch("result with no request waiting");
				return;
			end
			want = reports_due.pop_front();
			if (f !== want.found)
				report_mismatch($sformatf("cell_found %b, want %b", f, want.found));
			if (n !== want.number)
				report_mismatch($sformatf("cell_number %0d, want %0d", n, want.number));
			if (c !== want.changed)
				report_mismatch($sformatf("cell_changed %b, want %b", c, want.changed));
			if (l !== want.left)
				report_mismatch($sformatf("left_grid %b, want %b", l, want.left));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     mode = 1'b0;
	logic signed [31:0]       pos_x = '0, pos_y = '0, pos_z = '0;
	logic [9:0]               column_slot = '0;
	logic signed [31:0]       column_offset = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     cell_found;
	logic [14:0]              cell_number;
	logic                     cell_changed;
	logic                     left_grid;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [gcl_pkg::IDX_W-1:0] cfg_index = '0;
	logic [31:0]              cfg_data = '0;

	viewer_cell_tracker tracker = new();

	// stimulus-side view of the grid setting and column offsets
	longint             box_lo [3];
	longint             box_span [3];
	logic [5:0]         side_x = 6'd1, side_y = 6'd1;
	logic signed [31:0] offset_hint [1024] = '{default: '0};
	logic signed [31:0] last_x = '0, last_y = '0, last_z = '0;

	int unsigned send_idle_pct = 35;
	int unsigned recv_idle_pct = 69;
	int          hold_ask = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          quiet = 0;

	viewer_grid_cell_locator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.column_slot  (column_slot),
		.column_offset(column_offset),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cell_found   (cell_found),
		.cell_number  (cell_number),
		.cell_changed (cell_changed),
		.left_grid    (left_grid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			tracker.write_register(gcl_pkg::cfg_reg_t'(cfg_index), cfg_data);
		if (in_valid && !in_stall)
			tracker.take_request(mode, pos_x, pos_y, pos_z, column_slot, column_offset);
		if (out_valid && !out_stall)
			tracker.check_report(cell_found, cell_number, cell_changed, left_grid);
	end

	// Receiver: random stalls, plus a long hold-off whenever one is asked.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_ask) begin
			hold_seen <= hold_ask;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic longint unsigned rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int unsigned side_eff(logic [5:0] c);
		if (c == 0) return 1;
		return (c > gcl_pkg::MAX_SIDE) ? gcl_pkg::MAX_SIDE : c;
	endfunction

	// Pick a coordinate in cell k of an axis, or on its edges, or anywhere.
	function automatic logic signed [31:0] coord_near(longint lo, longint span, int unsigned cnt,
			int unsigned k);
		longint      a, b, p, c;
		int unsigned sel;
		sel = $urandom_range(99);
		if (span < 1) span = 1;
		c = cnt;
		a = (longint'(k) * span + c - 1) / c;
		b = (longint'(k + 1) * span + c - 1) / c;
		if (sel < 58)
			p = lo + a + ((b > a) ? longint'(rand64() % longint'(b - a)) : 64'sd0);
		else if (sel < 68) p = lo + a;
		else if (sel < 76) p = lo + b - 1;
		else if (sel < 83) p = lo + span;
		else if (sel < 87) p = lo;
		else if (sel < 91) p = lo - 1;
		else if (sel < 94) p = lo + span + 1;
		else p = longint'($signed($urandom));
		if (p < POS_MIN || p > POS_MAX) p = longint'($signed($urandom));
		return 32'(p);
	endfunction

	function automatic logic signed [31:0] pick_offset();
		int unsigned sel;
		longint      w;
		sel = $urandom_range(99);
		w = (box_span[2] > 0 && box_span[2] < 64'sd1073741824) ? box_span[2] : 64'sd4096;
		if (sel < 50) return 32'(longint'($urandom_range(0, 32'(2 * w))) - w);
		if (sel < 65) return '0;
		if (sel < 85) return $urandom;
		return ($urandom_range(1) != 0) ? 32'h7fffffff : 32'h80000000;
	endfunction

	function automatic void pick_box(int i);
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 25) box_span[i] = $urandom_range(1, 64);
		else if (sel < 75) box_span[i] = $urandom_range(65, 1 << 20);
		else box_span[i] = $urandom_range(1, 32'h7fffffff);
		box_lo[i] = POS_MIN + longint'(rand64() % longint'(64'sd4294967296 - box_span[i]));
	endfunction

	function automatic void choose_setting(int seg);
		int i;
		for (i = 0; i < 3; i++) pick_box(i);
		side_x = $urandom_range(1, 32);
		side_y = $urandom_range(1, 32);
		case (seg)
			0: begin
				for (i = 0; i < 3; i++) begin
					box_lo[i] = POS_MIN;
					box_span[i] = POS_MAX - POS_MIN;
				end
				side_x = 6'd32;
				side_y = 6'd32;
			end
			2: begin
				// upper bound at or below lower bound on one axis
				i = $urandom_range(2);
				box_lo[i] = longint'($signed($urandom_range(0, 32'h7fffffff))) - 64'sd1073741824;
				box_span[i] = -longint'($urandom_range(0, 1000));
			end
			3: begin
				side_x = 6'd63;
				side_y = $urandom_range(33, 62);
			end
			4: begin
				for (i = 0; i < 3; i++) box_span[i] = $urandom_range(1, 4);
			end
			5: begin
				if ($urandom_range(1) != 0) side_x = '0;
				else side_y = '0;
			end
			default: ;
		endcase
	endfunction

	task automatic apply_setting();
		int i;
		for (i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[gcl_pkg::IDX_W-1:0];
			case (gcl_pkg::cfg_reg_t'(i))
				gcl_pkg::REG_MIN_X, gcl_pkg::REG_MIN_Y, gcl_pkg::REG_MIN_Z:
					cfg_data <= 32'(box_lo[i]);
				gcl_pkg::REG_MAX_X, gcl_pkg::REG_MAX_Y, gcl_pkg::REG_MAX_Z:
					cfg_data <= 32'(box_lo[i - 3] + box_span[i - 3]);
				gcl_pkg::REG_CELLS_X: cfg_data <= {26'd0, side_x};
				default:              cfg_data <= {26'd0, side_y};
			endcase
			do @(posedge clk); while (cfg_ready !== 1'b1);
		end
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every result, then let the block drain.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (tracker.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic offer(logic m, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic [9:0] slot, logic signed [31:0] off);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 40 : 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		column_slot <= slot;
		column_offset <= off;
		if (m == gcl_pkg::MODE_COLUMN) offset_hint[slot] = off;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic locate(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
		offer(gcl_pkg::MODE_LOCATE, x, y, z, 10'($urandom_range(1023)), $urandom);
	endtask

	task automatic set_column(logic [9:0] slot, logic signed [31:0] off);
		offer(gcl_pkg::MODE_COLUMN, $urandom, $urandom, $urandom, slot, off);
	endtask

	task automatic random_item();
		int unsigned        cx, cy, kx, ky, col;
		logic signed [31:0] x, y, z;
		cx = side_eff(side_x);
		cy = side_eff(side_y);
		kx = $urandom_range(cx - 1);
		ky = $urandom_range(cy - 1);
		col = (kx + ky * cx) % 1024;
		if ($urandom_range(99) < 15) begin
			set_column(($urandom_range(99) < 70) ? col[9:0] : 10'($urandom_range(1023)),
				pick_offset());
		end else begin
			if ($urandom_range(99) < 15) begin
				// repeat the previous position: same cell, no reload
				x = last_x;
				y = last_y;
				z = last_z;
			end else begin
				x = coord_near(box_lo[0], box_span[0], cx, kx);
				y = coord_near(box_lo[1], box_span[1], cy, ky);
				z = coord_near(box_lo[2] + longint'(offset_hint[col]), box_span[2],
					gcl_pkg::GRID_DEPTH, $urandom_range(gcl_pkg::GRID_DEPTH - 1));
			end
			last_x = x;
			last_y = y;
			last_z = z;
			locate(x, y, z);
		end
	endtask

	initial begin
		int seg;
		int n;
		int quota;
		for (n = 0; n < 3; n++) begin
			box_lo[n] = 0;
			box_span[n] = 4096;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: 4096-wide box, one column, eight layers
		locate(0, 0, 0);
		locate(0, 0, 0);
		locate(4095, 4095, 4095);
		locate(0, 0, 4096);
		locate(0, 0, 4096);
		locate(4096, 0, 0);
		locate(-1, 0, 0);
		locate(32'h80000000, 32'h80000000, 32'h80000000);
		locate(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		set_column(10'd0, 32'sd2048);
		locate(100, 100, 5000);
		locate(100, 100, 2047);
		set_column(10'd1023, 32'h7fffffff);
		set_column(10'd0, 32'h7fffffff);
		locate(0, 0, 32'h7fffffff);
		set_column(10'd0, 32'h80000000);
		locate(0, 0, 32'h80000000);
		locate(0, 0, 32'h80001000);
		locate(2048, 2048, 32'h80000fff);
		set_column(10'd0, 32'sd0);

		for (seg = 0; seg < 8; seg++) begin
			settle();
			if (seg == 3) begin
				send_idle_pct <= 69;
				recv_idle_pct <= 35;
			end else if (seg == 6) begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
			choose_setting(seg);
			apply_setting();
			quota = (seg == 2 || seg == 5) ? 50 : 180;
			for (n = 0; n < quota; n++) begin
				if ((seg == 1 || seg == 6) && n == 20) hold_ask <= hold_ask + 1;
				random_item();
			end
		end
		settle();

		if (tracker.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/gcl_pkg.sv
sv/gcl_ram.sv
sv/gcl_div.sv
sv/viewer_grid_cell_locator.sv
bench/tb_viewer_grid_cell_locator.sv
